>>> rtl/core/rse_pkg.sv
// Shared types, codes and defaults for the postfix stack evaluator.
package rse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int ACTION_W        = 3;
    localparam int FIELD_W         = 32;
    localparam int FLAG_W          = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_END  = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP_R,
        S_POP_L,
        S_LOAD,
        S_START,
        S_WAIT,
        S_WB,
        S_OUT
    } t_state;

    typedef struct packed {
        t_action op;
        logic    load_item;
        logic    do_push;
        logic    pop;
        logic    cap_right;
        logic    cap_left;
        logic    start_unit;
        logic    wb;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic unit_done;
    } t_dp_stat;

endpackage

>>> rtl/core/rse_muldiv.sv
// Iterative radix-2 unit: low half of a product, or a signed quotient truncated toward zero.
module rse_muldiv
    import rse_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_is_div,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int NW = $clog2(DATA_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [NW-1:0]         r_cnt;
    logic                  r_is_div;
    logic                  r_neg;
    logic                  r_zero;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;
    logic [DATA_WIDTH-1:0] r_acc;

    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;

    assign mag_a  = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b  = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    // The dividend bits enter the partial remainder from the top of r_x.
    assign rem_sh = {r_acc, r_x[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DATA_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_div <= i_is_div;
            r_neg    <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            r_zero   <= (i_b == '0);
            r_acc    <= '0;
            r_x      <= i_is_div ? mag_a : i_a;
            r_y      <= i_is_div ? mag_b : i_b;
        end else if (r_busy) begin
            if (r_is_div) begin
                if (!diff[DATA_WIDTH]) begin
                    r_acc <= diff[DATA_WIDTH-1:0];
                end else begin
                    r_acc <= rem_sh[DATA_WIDTH-1:0];
                end
                r_x <= {r_x[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    always_comb begin
        if (!r_is_div) begin
            o_result = r_acc;
        end else if (r_zero) begin
            o_result = '0;
        end else if (r_neg) begin
            o_result = ~r_x + 1'b1;
        end else begin
            o_result = r_x;
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/core/rse_dp.sv
// Datapath: operand stack memory, stack count, operand registers and result register.
module rse_dp
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [FIELD_W-1:0] i_push_value,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_result_value,
    output logic               o_leftover_error,
    output logic               o_overflow_error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_pop_hit;
    logic [CW-1:0]         r_count;
    logic                  r_ovf;
    logic [DATA_WIDTH-1:0] r_push_val;
    logic [DATA_WIDTH-1:0] r_right;
    logic [DATA_WIDTH-1:0] r_left;
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_value;
    logic                  r_out_left;
    logic                  r_out_ovf;

    logic [DATA_WIDTH-1:0] push_ext;
    logic [FIELD_W-1:0]    right_sext;
    logic [CW-1:0]         cnt_m1;
    logic                  full;
    logic                  push_req;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] wb_val;
    logic [DATA_WIDTH-1:0] unit_result;
    logic                  unit_done;
    logic [DATA_WIDTH-1:0] pop_val;

    generate
        if (DATA_WIDTH > FIELD_W) begin : g_wide
            assign push_ext   = {{(DATA_WIDTH-FIELD_W){i_push_value[FIELD_W-1]}}, i_push_value};
            assign right_sext = r_right[FIELD_W-1:0];
        end else if (DATA_WIDTH == FIELD_W) begin : g_equal
            assign push_ext   = i_push_value;
            assign right_sext = r_right;
        end else begin : g_narrow
            assign push_ext   = i_push_value[DATA_WIDTH-1:0];
            assign right_sext = {{(FIELD_W-DATA_WIDTH){r_right[DATA_WIDTH-1]}}, r_right};
        end
    endgenerate

    rse_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start_unit),
        .i_is_div (i_cmd.op == ACT_DIV),
        .i_a      (r_left),
        .i_b      (r_right),
        .o_done   (unit_done),
        .o_result (unit_result)
    );

    assign cnt_m1   = r_count - CW'(1);
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign push_req = i_cmd.do_push || i_cmd.wb;
    assign wr_en    = push_req && !full;
    assign pop_val  = r_pop_hit ? r_rd_data : '0;

    always_comb begin
        case (i_cmd.op)
            ACT_ADD: wb_val = r_left + r_right;
            ACT_SUB: wb_val = r_left - r_right;
            default: wb_val = unit_result;
        endcase
    end

    assign wr_data = i_cmd.do_push ? r_push_val : wb_val;

    // The top entry is always read into a register, so a pop has its data in the cycle after it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[cnt_m1[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop && (r_count != '0)) begin
                r_count <= cnt_m1;
            end

            if (i_cmd.out_load) begin
                r_ovf <= 1'b0;
            end else if (push_req && full) begin
                r_ovf <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_hit <= i_cmd.pop && (r_count != '0);
        if (i_cmd.load_item) begin
            r_push_val <= push_ext;
        end
        if (i_cmd.cap_right) begin
            r_right <= pop_val;
        end
        if (i_cmd.cap_left) begin
            r_left <= pop_val;
        end
        if (i_cmd.out_load) begin
            r_out_value <= right_sext;
            r_out_left  <= (r_count != '0);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_stat.out_busy  = r_out_valid && !i_out_ready;
    assign o_stat.unit_done = unit_done;

    assign o_out_valid      = r_out_valid;
    assign o_result_value   = r_out_value;
    assign o_leftover_error = r_out_left;
    assign o_overflow_error = r_out_ovf;

endmodule

>>> rtl/core/rse_ctrl.sv
// Controller: steps each arithmetic request through pops, the operation and push back.
module rse_ctrl
    import rse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_action  i_in_action,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_action r_op;
    t_action n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= ACT_PUSH;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_op            = i_in_action;
                    case (i_in_action)
                        ACT_PUSH: n_state = S_PUSH;
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_END: n_state = S_POP_R;
                        // Unused codes leave the stack untouched.
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.do_push = 1'b1;
                n_state       = S_IDLE;
            end
            S_POP_R: begin
                o_cmd.pop = 1'b1;
                n_state   = S_POP_L;
            end
            S_POP_L: begin
                o_cmd.cap_right = 1'b1;
                if (r_op == ACT_END) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.cap_left = 1'b1;
                if (r_op == ACT_ADD || r_op == ACT_SUB) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start_unit = 1'b1;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.unit_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_IDLE;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/rpn_stack_evaluator.sv
// Top level of the postfix stack evaluator.
//
// Input stream: one request per operation. s_axis_tuser carries the action
// (push, add, subtract, multiply, divide, end) and s_axis_tdata the signed
// constant used by a push. Output stream: one result per end request, with
// the popped value in m_axis_tdata and the two error flags in m_axis_tuser.
// Requests are taken one at a time; s_axis_tready is high while the
// controller is idle. A multiply or divide waits on the radix-2 unit that
// retires one bit per cycle. After an end request is accepted, the
// controller pops the top entry and loads it into the output register once
// it is free or being drained. The result sits in an output register, so
// further requests are taken while it waits; only a second end request
// stalls until the first result is taken. Reset empties the stack, clears
// the overflow flag and drops any pending result. Stack contents are not
// cleared: only entries below the count are ever read.
module rpn_stack_evaluator
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [FIELD_W-1:0]  s_axis_tdata,   // [31:0] push_value
    input  logic [ACTION_W-1:0] s_axis_tuser,   // [2:0] action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [FIELD_W-1:0]  m_axis_tdata,   // [31:0] result_value
    output logic [FLAG_W-1:0]   m_axis_tuser    // [0] leftover_error, [1] overflow_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     leftover_error;
    logic     overflow_error;

    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (t_action'(s_axis_tuser)),
        .o_in_ready  (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rse_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_push_value     (s_axis_tdata),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_result_value   (m_axis_tdata),
        .o_leftover_error (leftover_error),
        .o_overflow_error (overflow_error)
    );

    assign m_axis_tuser = {overflow_error, leftover_error};

`ifndef SYNTHESIS
    // A result is only loaded when the output register is free or being drained.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded over a pending result");

    // The arithmetic unit only finishes while a request is in progress.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.unit_done |-> !s_axis_tready)
        else $error("arithmetic unit finished while idle");

    // An accepted end request always occupies the controller afterwards.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_END)) |=> !s_axis_tready)
        else $error("end request did not start a report");

    // Loading a result makes it visible on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the postfix stack evaluator with its own operand-stack predictor.
module testbench
    import rse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int ITEM_TARGET   = 1800;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 30;

    // Action codes the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    localparam logic [FIELD_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [FIELD_W-1:0] MINUS_1 = 32'hffff_ffff;

    typedef struct {
        logic [FIELD_W-1:0] value;
        logic               leftover;
        logic               overflow;
    } t_end_report;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [FIELD_W-1:0]  s_axis_tdata  = '0;   // [31:0] push_value
    logic [ACTION_W-1:0] s_axis_tuser  = '0;   // [2:0] action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [FIELD_W-1:0]  m_axis_tdata;         // [31:0] result_value
    logic [FLAG_W-1:0]   m_axis_tuser;         // [0] leftover_error, [1] overflow_error

    rpn_stack_evaluator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predicted operand stack.
    logic [FIELD_W-1:0] calc_stack [DEPTH];
    int unsigned        calc_depth    = 0;
    bit                 calc_overflow = 1'b0;
    t_end_report        end_reports_due [$];

    int  requests_sent      = 0;
    int  reports_checked    = 0;
    int  overflow_reports   = 0;
    int  leftover_reports   = 0;
    int  mismatches         = 0;
    int  input_stall_cycles = 0;
    int  cycle_count        = 0;
    bit  tx_gaps_on         = 1'b1;

    // Receiver state; hold requests arrive as a token count so both sides stay ordered.
    int  hold_tokens      = 0;
    int  hold_tokens_seen = 0;
    int  hold_left        = 0;
    int  stall_left       = 0;
    int  calm_left        = 0;
    int  held_cycles      = 0;
    bit  ready_next;

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return '0;
            3: return MINUS_1;
            4, 5, 6: return FIELD_W'($urandom_range(0, 40)) - FIELD_W'(20);
            default: return $urandom();
        endcase
    endfunction

    function automatic void calc_push(logic [FIELD_W-1:0] val);
        if (calc_depth >= DEPTH) begin
            calc_overflow = 1'b1;
        end else begin
            calc_stack[calc_depth] = val;
            calc_depth++;
        end
    endfunction

    function automatic logic [FIELD_W-1:0] calc_pop();
        if (calc_depth == 0) return '0;
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // Truncating signed quotient; a zero divisor gives zero, and the most
    // negative value over minus one wraps back to itself.
    function automatic logic [FIELD_W-1:0] quotient_trunc(logic [FIELD_W-1:0] lhs,
                                                          logic [FIELD_W-1:0] rhs);
        longint sl, sr;
        sl = longint'($signed(lhs));
        sr = longint'($signed(rhs));
        if (rhs == '0) return '0;
        return FIELD_W'(sl / sr);
    endfunction

    function automatic void model_request(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] val);
        logic [FIELD_W-1:0] rhs, lhs, res;
        t_end_report        rep;
        case (act)
            ACT_PUSH: calc_push(val);
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                rhs = calc_pop();
                lhs = calc_pop();
                case (act)
                    ACT_ADD: res = lhs + rhs;
                    ACT_SUB: res = lhs - rhs;
                    ACT_MUL: res = lhs * rhs;
                    default: res = quotient_trunc(lhs, rhs);
                endcase
                calc_push(res);
            end
            ACT_END: begin
                rep.value    = calc_pop();
                rep.leftover = (calc_depth != 0);
                rep.overflow = calc_overflow;
                end_reports_due.push_back(rep);
                calc_depth    = 0;
                calc_overflow = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on report %0d: %s got %h expected %h",
                     $realtime, reports_checked, what, got, want);
    endtask

    // Entered and left at a falling edge; tvalid stays high after acceptance so
    // that back-to-back requests need no second assignment in one step.
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [FIELD_W-1:0] val);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_request(act, val);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (end_reports_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_arithmetic_edges();
        // Addition wraps past the largest value.
        send_request(ACT_PUSH, INT_MAX);
        send_request(ACT_PUSH, 32'd1);
        send_request(ACT_ADD, $urandom());
        send_request(ACT_END, $urandom());
        // The most negative value over minus one wraps to itself.
        send_request(ACT_PUSH, INT_MIN);
        send_request(ACT_PUSH, MINUS_1);
        send_request(ACT_DIV, $urandom());
        send_request(ACT_END, $urandom());
        // Truncation toward zero, division by zero, then subtract and multiply.
        send_request(ACT_PUSH, -32'sd7);
        send_request(ACT_PUSH, 32'd2);
        send_request(ACT_DIV, $urandom());
        send_request(ACT_PUSH, 32'd5);
        send_request(ACT_PUSH, 32'd0);
        send_request(ACT_DIV, $urandom());
        send_request(ACT_SUB, $urandom());
        send_request(ACT_PUSH, 32'd3);
        send_request(ACT_MUL, $urandom());
        send_request(ACT_END, $urandom());
        drain_results();
    endtask

    task automatic test_empty_and_spare_codes();
        // An operation on an empty stack combines two zeros.
        send_request(ACT_ADD, $urandom());
        send_request(ACT_END, $urandom());
        // Spare codes change nothing, and the end then finds an empty stack.
        send_request(ACT_SPARE_A, $urandom());
        send_request(ACT_SPARE_B, $urandom());
        send_request(ACT_END, $urandom());
        // Entries left below the popped top are flagged.
        send_request(ACT_PUSH, 32'd1);
        send_request(ACT_PUSH, 32'd2);
        send_request(ACT_END, $urandom());
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        hold_tokens <= hold_tokens + 1;
        // Once a second end request is taken, the input stalls until the output is read.
        repeat (8) begin
            send_request(ACT_PUSH, random_operand());
            send_request(ACT_END, $urandom());
        end
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    // Program: pushes interleaved with operations to one entry, an optional extra push, an end.
    task automatic run_program(int pushes, int push_pct, bit add_leftover);
        while (pushes > 0 || calc_depth > 1) begin
            if (pushes > 0 && (calc_depth < 2 || $urandom_range(0, 99) < push_pct)) begin
                send_request(ACT_PUSH, random_operand());
                pushes--;
            end else begin
                send_request(ACTION_W'($urandom_range(ACT_ADD, ACT_DIV)), $urandom());
            end
        end
        if (add_leftover) send_request(ACT_PUSH, random_operand());
        send_request(ACT_END, $urandom());
    endtask

    task automatic test_random_programs();
        int kind, n;
        while (requests_sent < ITEM_TARGET + 30) begin
            if ($urandom_range(0, 9) == 0) tx_gaps_on = !tx_gaps_on;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                run_program($urandom_range(1, 10), 50, ($urandom_range(0, 19) == 0));
            end else if (kind < 80) begin
                // Fill close to or past the stack depth, so that pushes may be dropped.
                run_program($urandom_range(15, 21), 100, 1'b0);
            end else if (kind < 92) begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(ACTION_W'($urandom_range(0, 7)), random_operand());
                send_request(ACT_END, $urandom());
            end else begin
                // Too many operations: the tail pops from an empty stack.
                n = $urandom_range(1, 4);
                repeat (n) send_request(ACT_PUSH, random_operand());
                repeat (n + $urandom_range(0, 3))
                    send_request(ACTION_W'($urandom_range(ACT_ADD, ACT_DIV)), $urandom());
                send_request(ACT_END, $urandom());
            end
        end
        drain_results();
    endtask

    // Receiver: random stalls, quiet stretches, and a long hold when asked.
    always @(negedge i_clk) begin
        if (hold_tokens != hold_tokens_seen) begin
            hold_tokens_seen = hold_tokens;
            hold_left        = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            held_cycles++;
            ready_next = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 199) == 0)
                calm_left = $urandom_range(50, 300);
            if (calm_left == 0 && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap() - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
        end
        m_axis_tready <= ready_next;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_end_report due;
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (end_reports_due.size() == 0) begin
                    report_mismatch("unexpected result_value", m_axis_tdata, '0);
                end else begin
                    due = end_reports_due.pop_front();
                    if (m_axis_tdata !== due.value)
                        report_mismatch("result_value", m_axis_tdata, due.value);
                    if (m_axis_tuser[0] !== due.leftover)
                        report_mismatch("leftover_error", FIELD_W'(m_axis_tuser[0]),
                                        FIELD_W'(due.leftover));
                    if (m_axis_tuser[1] !== due.overflow)
                        report_mismatch("overflow_error", FIELD_W'(m_axis_tuser[1]),
                                        FIELD_W'(due.overflow));
                    if (due.overflow) overflow_reports++;
                    if (due.leftover) leftover_reports++;
                end
                reports_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, end_reports_due.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_arithmetic_edges();
        test_empty_and_spare_codes();
        test_output_backpressure();
        test_random_programs();
        $display("sent %0d requests; checked %0d end reports", requests_sent, reports_checked);
        $display("(%0d with dropped pushes, %0d with leftovers)",
                 overflow_reports, leftover_reports);
        $display("output held off %0d cycles; input stalled %0d cycles; %0d mismatches",
                 held_cycles, input_stall_cycles, mismatches);
        if (mismatches == 0 && end_reports_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rse_pkg.sv
rtl/core/rse_muldiv.sv
rtl/core/rse_dp.sv
rtl/core/rse_ctrl.sv
rtl/core/rpn_stack_evaluator.sv
tb/sv/testbench.sv
